### hw/rtl/aip_pkg.sv
`timescale 1ns / 1ps

package aip_pkg;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_SIGN,
        PH_PCT,
        PH_DIG
    } phase_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RADIX    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [4:0] RADIX_BIN   = 5'd2;
    localparam logic [4:0] RADIX_DEC   = 5'd10;
    localparam logic [4:0] RADIX_HEX   = 5'd16;
    localparam logic [4:0] RADIX_RESET = RADIX_DEC;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_A_UP  = 8'h41;
    localparam logic [7:0] CHAR_B_UP  = 8'h42;
    localparam logic [7:0] CHAR_D_UP  = 8'h44;
    localparam logic [7:0] CHAR_F_UP  = 8'h46;
    localparam logic [7:0] CHAR_X_UP  = 8'h58;
    localparam logic [7:0] CHAR_A_LO  = 8'h61;
    localparam logic [7:0] CHAR_B_LO  = 8'h62;
    localparam logic [7:0] CHAR_D_LO  = 8'h64;
    localparam logic [7:0] CHAR_F_LO  = 8'h66;
    localparam logic [7:0] CHAR_X_LO  = 8'h78;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        unique case (c) inside
            [CHAR_0:CHAR_9]:       h.val = 4'(c - CHAR_0);
            [CHAR_A_UP:CHAR_F_UP]: h.val = 4'(c - CHAR_A_UP + 8'd10);
            [CHAR_A_LO:CHAR_F_LO]: h.val = 4'(c - CHAR_A_LO + 8'd10);
            default:               h.ok  = 1'b0;
        endcase
        return h;
    endfunction

endpackage

### hw/rtl/aip_in_stage.sv
`timescale 1ns / 1ps

module aip_in_stage import aip_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       out_free,
    output logic       step,
    output logic [7:0] char_q
);

    logic       char_valid_reg;
    logic       char_valid_next;
    logic [7:0] char_reg;

    // a terminator only moves on when the result slot can take it
    assign step     = char_valid_reg && ((char_reg != CHAR_NUL) || out_free);
    assign in_ready = !char_valid_reg || step;
    assign char_q   = char_reg;

    always_comb
    begin
        char_valid_next = char_valid_reg;
        if (in_ready)
        begin
            char_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
        end
        else
        begin
            char_valid_reg <= char_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_code;
        end
    end

endmodule

### hw/rtl/aip_parse.sv
`timescale 1ns / 1ps

module aip_parse import aip_pkg::*;
#(
    parameter int RESULT_BYTES = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [4:0] cfg_data,
    input  logic       step,
    input  logic [7:0] char_q,
    output logic       done,
    output result_t    result
);

    localparam int W  = 8 * RESULT_BYTES;
    localparam int PW = W + 6;

    phase_t        phase_reg, phase_next, phase_eff;
    logic          neg_reg, neg_next;
    logic [4:0]    radix_reg, radix_next;
    logic [4:0]    default_radix_reg;
    logic [W-1:0]  acc_reg, acc_next;
    logic [1:0]    err_reg, err_next;
    logic [4:0]    radix_cur;
    logic          take;
    logic          is_space;
    hex_t          hex;
    logic [PW-1:0] prod;
    logic [W-1:0]  value_w;
    logic [W+31:0] value_ext;

    assign is_space = (char_q == CHAR_SPACE) || ((char_q >= CHAR_TAB) && (char_q <= CHAR_CR));
    assign hex      = hex_decode(char_q);
    assign radix_cur = (phase_reg == PH_LEAD) ? default_radix_reg : radix_reg;
    assign prod     = PW'(acc_reg) * PW'(radix_cur) + PW'(hex.val);

    // result is formed from the state before the terminator clears it
    assign value_w   = ((err_reg == ST_OK) && neg_reg) ? (~acc_reg + W'(1)) : acc_reg;
    assign value_ext = {32'd0, value_w};
    assign result    = {value_ext[31:0], err_reg};
    assign done = step && (char_q == CHAR_NUL);

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        radix_next = radix_reg;
        acc_next   = acc_reg;
        err_next   = err_reg;
        phase_eff  = phase_reg;
        take       = 1'b0;
        if (step)
        begin
            if (char_q == CHAR_NUL)
            begin
                phase_next = PH_LEAD;
                neg_next   = 1'b0;
                radix_next = default_radix_reg;
                acc_next   = '0;
                err_next   = ST_OK;
            end
            else if (err_reg == ST_OK)
            begin
                radix_next = radix_cur;
                if (phase_reg == PH_LEAD)
                begin
                    if (char_q == CHAR_MINUS)
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_SIGN;
                    end
                    else if (!is_space)
                    begin
                        phase_next = PH_SIGN;
                        phase_eff  = PH_SIGN;
                    end
                end
                unique case (phase_eff)
                    PH_LEAD:
                    begin
                    end
                    PH_SIGN:
                    begin
                        if (char_q == CHAR_PCT)
                        begin
                            phase_next = PH_PCT;
                        end
                        else
                        begin
                            take = 1'b1;
                        end
                    end
                    PH_PCT:
                    begin
                        if ((char_q == CHAR_B_LO) || (char_q == CHAR_B_UP))
                        begin
                            radix_next = RADIX_BIN;
                            phase_next = PH_DIG;
                        end
                        else if ((char_q == CHAR_D_LO) || (char_q == CHAR_D_UP))
                        begin
                            radix_next = RADIX_DEC;
                            phase_next = PH_DIG;
                        end
                        else if ((char_q == CHAR_X_LO) || (char_q == CHAR_X_UP))
                        begin
                            radix_next = RADIX_HEX;
                            phase_next = PH_DIG;
                        end
                        else
                        begin
                            take = 1'b1;
                        end
                    end
                    PH_DIG:
                    begin
                        take = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                if (take)
                begin
                    if (!hex.ok || ({1'b0, hex.val} >= radix_cur))
                    begin
                        err_next = ST_RADIX;
                    end
                    else
                    begin
                        phase_next = PH_DIG;
                        acc_next   = prod[W-1:0];
                        if (|prod[PW-1:W])
                        begin
                            err_next = ST_OVERFLOW;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_LEAD;
            neg_reg           <= 1'b0;
            radix_reg         <= RADIX_RESET;
            acc_reg           <= '0;
            err_reg           <= ST_OK;
            default_radix_reg <= RADIX_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            radix_reg <= radix_next;
            acc_reg   <= acc_next;
            err_reg   <= err_next;
            if (cfg_we)
            begin
                default_radix_reg <= cfg_data;
            end
        end
    end

endmodule

### hw/rtl/aip_out_stage.sv
`timescale 1ns / 1ps

module aip_out_stage import aip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  result_t     result,
    output logic        out_free,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] value,
    output logic [1:0]  status
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign value     = result_reg.value;
    assign status    = result_reg.status;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

### hw/rtl/ascii_integer_parser_core.sv
`timescale 1ns / 1ps
// a terminator passes the input char register, then loads the output register
// throughput: one character item per cycle, as the multiply-add on the
// accumulator is combinational; only a terminator stalls, while a result waits
// reset: parse state cleared, default radix 10, no item held on either side
module ascii_integer_parser_core import aip_pkg::*;
#(
    parameter int RESULT_BYTES = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] value,
    output logic [1:0]  status
);

    logic       out_free;
    logic       step;
    logic       done;
    logic [7:0] char_q;
    result_t    result;

    assign cfg_ready = 1'b1;

    aip_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .out_free  (out_free),
        .step      (step),
        .char_q    (char_q)
    );

    aip_parse #(
        .RESULT_BYTES (RESULT_BYTES)
    ) u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .step     (step),
        .char_q   (char_q),
        .done     (done),
        .result   (result)
    );

    aip_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (done),
        .result    (result),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .status    (status)
    );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import aip_pkg::*;

    localparam int ITEM_TARGET = 750;
    localparam int PHASE_ITEMS = 95;
    localparam int HOLD_CYCLES = 250;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DIR_ROWS_N = 25;

    typedef struct packed {
        logic [7:0]  ch;
        bit          typed;
        logic [31:0] value;
        logic [1:0]  status;
    } dir_row_t;

    // typed expectations only on terminators whose result is obvious
    localparam dir_row_t DIR_ROWS [0:DIR_ROWS_N-1] = '{
        '{CHAR_NUL,   1'b1, 32'd0, ST_OK},
        '{CHAR_MINUS, 1'b0, 32'd0, ST_OK},
        '{CHAR_NUL,   1'b1, 32'd0, ST_OK},
        '{CHAR_PCT,   1'b0, 32'd0, ST_OK},
        '{CHAR_NUL,   1'b1, 32'd0, ST_OK},
        '{"g",        1'b0, 32'd0, ST_OK},
        '{CHAR_NUL,   1'b1, 32'd0, ST_RADIX},
        '{CHAR_SPACE, 1'b0, 32'd0, ST_OK},
        '{CHAR_MINUS, 1'b0, 32'd0, ST_OK},
        '{CHAR_PCT,   1'b0, 32'd0, ST_OK},
        '{CHAR_X_UP,  1'b0, 32'd0, ST_OK},
        '{CHAR_F_UP,  1'b0, 32'd0, ST_OK},
        '{CHAR_F_LO,  1'b0, 32'd0, ST_OK},
        '{CHAR_NUL,   1'b0, 32'd0, ST_OK},
        '{8'hFF,      1'b0, 32'd0, ST_OK},
        '{CHAR_NUL,   1'b1, 32'd0, ST_RADIX},
        '{CHAR_TAB,   1'b0, 32'd0, ST_OK},
        '{CHAR_9,     1'b0, 32'd0, ST_OK},
        '{CHAR_A_LO,  1'b0, 32'd0, ST_OK},
        '{CHAR_NUL,   1'b1, 32'd9, ST_RADIX},
        '{CHAR_PCT,   1'b0, 32'd0, ST_OK},
        '{CHAR_B_LO,  1'b0, 32'd0, ST_OK},
        '{"1",        1'b0, 32'd0, ST_OK},
        '{CHAR_MINUS, 1'b0, 32'd0, ST_OK},
        '{CHAR_NUL,   1'b1, 32'd1, ST_RADIX}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = 5'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  char_code = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] value;
    logic [1:0]  status;

    // parser state as predicted
    phase_t      prs_phase;
    logic        prs_negative;
    logic [4:0]  prs_radix;
    logic [31:0] prs_acc;
    logic [1:0]  prs_err;
    logic [4:0]  cfg_radix;

    result_t     pending_results [$];
    logic [7:0]  str_chars [$];

    int          items_sent = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          hold_left = 0;
    bit          hold_req = 1'b0;
    bit          quiet_stretch = 1'b0;
    result_t     exp_r;

    ascii_integer_parser_core #(.RESULT_BYTES(4)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .status    (status)
    );

    always #5 clk = ~clk;

    function void clear_parse();
        prs_phase    = PH_LEAD;
        prs_negative = 1'b0;
        prs_radix    = cfg_radix;
        prs_acc      = 32'd0;
        prs_err      = ST_OK;
    endfunction

    function void fold_digit(input logic [7:0] c);
        logic [4:0]  d;
        logic [63:0] wide;
        bit          is_hex;
        is_hex = 1'b1;
        d = 5'd0;
        if (c >= CHAR_0 && c <= CHAR_9)
            d = 5'(c - CHAR_0);
        else if (c >= CHAR_A_UP && c <= CHAR_F_UP)
            d = 5'(c - CHAR_A_UP + 8'd10);
        else if (c >= CHAR_A_LO && c <= CHAR_F_LO)
            d = 5'(c - CHAR_A_LO + 8'd10);
        else
            is_hex = 1'b0;
        if (!is_hex || d >= prs_radix)
        begin
            prs_err = ST_RADIX;
            return;
        end
        prs_phase = PH_DIG;
        wide = 64'(prs_acc) * 64'(prs_radix) + 64'(d);
        if (wide[63:32] != 32'd0)
            prs_err = ST_OVERFLOW;
        prs_acc = wide[31:0];
    endfunction

    function void parse_char(input logic [7:0] c, output bit emits, output result_t res);
        emits = 1'b0;
        res = '0;
        if (c == CHAR_NUL)
        begin
            res.value  = (prs_err == ST_OK && prs_negative) ? -prs_acc : prs_acc;
            res.status = prs_err;
            emits = 1'b1;
            clear_parse();
            return;
        end
        if (prs_err != ST_OK)
            return;
        if (prs_phase == PH_LEAD)
        begin
            prs_radix = cfg_radix;
            if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))
                return;
            prs_phase = PH_SIGN;
            if (c == CHAR_MINUS)
            begin
                prs_negative = 1'b1;
                return;
            end
        end
        if (prs_phase == PH_SIGN)
        begin
            if (c == CHAR_PCT)
                prs_phase = PH_PCT;
            else
                fold_digit(c);
            return;
        end
        if (prs_phase == PH_PCT)
        begin
            if (c == CHAR_B_LO || c == CHAR_B_UP)
            begin
                prs_radix = RADIX_BIN;
                prs_phase = PH_DIG;
                return;
            end
            if (c == CHAR_D_LO || c == CHAR_D_UP)
            begin
                prs_radix = RADIX_DEC;
                prs_phase = PH_DIG;
                return;
            end
            if (c == CHAR_X_LO || c == CHAR_X_UP)
            begin
                prs_radix = RADIX_HEX;
                prs_phase = PH_DIG;
                return;
            end
        end
        fold_digit(c);
    endfunction

    task automatic send_char(input logic [7:0] c, input bit use_typed, input result_t typed_r);
        bit      emits;
        result_t res;
        in_valid  <= 1'b1;
        char_code <= c;
        do
            @(posedge clk);
        while (!in_ready);
        parse_char(c, emits, res);
        if (emits)
            pending_results.push_back(use_typed ? typed_r : res);
        items_sent++;
        if (!quiet_stretch)
        begin
            while ($urandom_range(99) < 28)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    task automatic write_radix(input logic [4:0] r);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_radix = r;
        if (prs_phase == PH_LEAD)
            prs_radix = r;
    endtask

    task automatic build_string();
        int         kind;
        int         n;
        int         i;
        int         r;
        int         lim;
        logic [4:0] eff;
        logic [4:0] d;
        logic [7:0] c;
        string      dec_head;
        dec_head = "429496729";
        str_chars.delete();
        kind = $urandom_range(99);
        if (kind < 10)
        begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
                str_chars.push_back(8'($urandom_range(1, 255)));
        end
        else
        begin
            n = $urandom_range(0, 2);
            for (i = 0; i < n; i++)
            begin
                r = $urandom_range(5);
                str_chars.push_back(r == 5 ? CHAR_SPACE : 8'(CHAR_TAB + r));
            end
            if ($urandom_range(2) == 0)
                str_chars.push_back(CHAR_MINUS);
            if (kind < 16)
            begin
                // decimal strings right at the top of the range
                str_chars.push_back(CHAR_PCT);
                str_chars.push_back($urandom_range(1) ? CHAR_D_LO : CHAR_D_UP);
                for (i = 0; i < 9; i++)
                    str_chars.push_back(dec_head[i]);
                str_chars.push_back(8'(CHAR_0 + $urandom_range(4, 7)));
            end
            else
            begin
                eff = cfg_radix;
                case ($urandom_range(9))
                    0:
                    begin
                        str_chars.push_back(CHAR_PCT);
                        str_chars.push_back($urandom_range(1) ? CHAR_B_LO : CHAR_B_UP);
                        eff = RADIX_BIN;
                    end
                    1:
                    begin
                        str_chars.push_back(CHAR_PCT);
                        str_chars.push_back($urandom_range(1) ? CHAR_D_LO : CHAR_D_UP);
                        eff = RADIX_DEC;
                    end
                    2, 3:
                    begin
                        str_chars.push_back(CHAR_PCT);
                        str_chars.push_back($urandom_range(1) ? CHAR_X_LO : CHAR_X_UP);
                        eff = RADIX_HEX;
                    end
                    4: str_chars.push_back(CHAR_PCT);
                    default: ;
                endcase
                r = $urandom_range(99);
                if (r < 5)
                    n = 0;
                else if (r < 65)
                    n = $urandom_range(1, 4);
                else if (r < 88)
                    n = $urandom_range(5, 12);
                else
                    n = $urandom_range(20, 34);
                lim = (eff == 5'd0 || eff > RADIX_HEX) ? 16 : int'(eff);
                for (i = 0; i < n; i++)
                begin
                    d = 5'($urandom_range(lim - 1));
                    if (d < 5'd10)
                        c = 8'(CHAR_0 + d);
                    else
                        c = 8'(($urandom_range(1) ? CHAR_A_UP : CHAR_A_LO) + d - 5'd10);
                    str_chars.push_back(c);
                end
            end
            if (kind >= 80)
            begin
                case ($urandom_range(3))
                    0: c = 8'($urandom_range(1, 255));
                    1: c = CHAR_PCT;
                    2: c = CHAR_MINUS;
                    default: c = CHAR_SPACE;
                endcase
                str_chars.insert($urandom_range(str_chars.size()), c);
            end
        end
        str_chars.push_back(CHAR_NUL);
    endtask

    task automatic note_mismatch(input result_t want, input bit unexpected);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            if (unexpected)
                $display("unexpected result: value %h status %0d", value, status);
            else
                $display("result mismatch: expected value %h status %0d, got value %h status %0d",
                         want.value, want.status, value, status);
        end
    endtask

    // output side: checking and back-pressure
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                note_mismatch('0, 1'b1);
            else
            begin
                exp_r = pending_results.pop_front();
                if (value !== exp_r.value || status !== exp_r.status)
                    note_mismatch(exp_r, 1'b0);
            end
        end
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (!quiet_stretch && $urandom_range(99) < 28)
            out_ready <= 1'b0;
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int      k;
        int      j;
        int      phase_start;
        result_t typed_r;
        cfg_radix = RADIX_RESET;
        clear_parse();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (j = 0; j < DIR_ROWS_N; j++)
        begin
            typed_r.value  = DIR_ROWS[j].value;
            typed_r.status = DIR_ROWS[j].status;
            send_char(DIR_ROWS[j].ch, DIR_ROWS[j].typed, typed_r);
        end

        k = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (k)
                0: write_radix(RADIX_HEX);
                1: write_radix(RADIX_BIN);
                2: write_radix(5'd0);
                3: write_radix(5'd1);
                4: write_radix(5'd31);
                5: write_radix(RADIX_DEC);
                default:
                    write_radix($urandom_range(1) ? 5'($urandom_range(2, 16))
                                                  : 5'($urandom_range(17, 30)));
            endcase
            quiet_stretch = (k == 5);
            // long receiver hold-off while characters keep coming
            if (k == 6)
                hold_req = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEM_TARGET)
            begin
                build_string();
                for (j = 0; j < str_chars.size(); j++)
                    send_char(str_chars[j], 1'b0, '0);
            end
            k++;
        end
        quiet_stretch = 1'b0;

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### ascii_integer_parser_core.f
hw/rtl/aip_pkg.sv
hw/rtl/aip_in_stage.sv
hw/rtl/aip_parse.sv
hw/rtl/aip_out_stage.sv
hw/rtl/ascii_integer_parser_core.sv
tb/tb_top.sv
